FILE: rtl/core/ist_pkg.sv
package ist_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_BITS  = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CMP_W      = (CNT_W > 6) ? CNT_W : 6;
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int NGROUPS    = (CAPACITY + LANES - 1) / LANES;
    localparam int GRP_W      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int SCAN_IDX_W = GRP_W + LANE_W;

    typedef enum logic [2:0] {
        KIND_INSERT  = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_SELECT  = 3'd2,
        KIND_SEARCH  = 3'd3,
        KIND_REPLACE = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_REPLACE,
        CELL_SEARCH
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [CNT_W-1:0]       pos;
        logic [CNT_W-1:0]       count;
        logic [WORD_BITS-1:0]   word;
    } cell_ctl_t;

    typedef struct packed {
        logic                   done;
        logic                   hit;
        logic [SCAN_IDX_W-1:0]  index;
    } scan_res_t;

endpackage

FILE: rtl/core/ist_if.sv
interface ist_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] word;

    modport source (output valid, output kind, output position, output word, input ready);
    modport sink (input valid, input kind, input position, input word, output ready);
endinterface

interface ist_rsp_if;
    logic               valid;
    logic               ready;
    logic               ok;
    logic signed [31:0] read_word;
    logic [6:0]         found_position;
    logic [6:0]         entry_count;
    logic               is_empty;
    logic               is_full;

    modport source (
        output valid, output ok, output read_word, output found_position,
        output entry_count, output is_empty, output is_full, input ready
    );
    modport sink (
        input valid, input ok, input read_word, input found_position,
        input entry_count, input is_empty, input is_full, output ready
    );
endinterface

FILE: rtl/core/ist_cell.sv
module ist_cell
    import ist_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctl_t            ctl,
    input  logic [CNT_W-1:0]     idx,
    input  logic [WORD_BITS-1:0] left_data,
    input  logic [WORD_BITS-1:0] right_data,
    output logic [WORD_BITS-1:0] data,
    output logic                 match
);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic                 match_reg;
    logic                 match_next;
    logic [CNT_W:0]       idx_plus;

    assign idx_plus = {1'b0, idx} + {{CNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (idx == ctl.pos)
                begin
                    data_next = ctl.word;
                end
                else if (idx > ctl.pos && idx <= ctl.count)
                begin
                    data_next = left_data;
                end
            end
            CELL_REMOVE:
            begin
                // close the gap: everything above the removed slot moves down
                if (idx >= ctl.pos && idx_plus < {1'b0, ctl.count})
                begin
                    data_next = right_data;
                end
            end
            CELL_REPLACE:
            begin
                if (idx == ctl.pos)
                begin
                    data_next = ctl.word;
                end
            end
            CELL_SEARCH:
            begin
                match_next = (data_reg == ctl.word) && (idx < ctl.count);
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

FILE: rtl/core/ist_scan.sv
module ist_scan
    import ist_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CAPACITY-1:0] match,
    output scan_res_t           res
);

    logic [NGROUPS*LANES-1:0] match_pad;
    logic [LANES-1:0]         slice;
    logic [LANE_W-1:0]        lane;
    logic                     any_hit;
    logic                     last_group;
    logic                     busy_reg;
    logic                     busy_next;
    logic [GRP_W-1:0]         group_reg;
    logic [GRP_W-1:0]         group_next;

    assign match_pad  = (NGROUPS*LANES)'(match);
    assign slice      = match_pad[group_reg*LANES +: LANES];
    assign any_hit    = |slice;
    assign last_group = (group_reg == GRP_W'(NGROUPS - 1));

    // lowest set lane wins
    always_comb
    begin
        lane = '0;
        for (int k = LANES - 1; k >= 0; k--)
        begin
            if (slice[k])
            begin
                lane = LANE_W'(k);
            end
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        group_next = group_reg;
        res.done   = 1'b0;
        res.hit    = any_hit;
        res.index  = {group_reg, lane};
        if (start)
        begin
            busy_next  = 1'b1;
            group_next = '0;
        end
        else if (busy_reg)
        begin
            if (any_hit || last_group)
            begin
                res.done  = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                group_next = group_reg + GRP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            group_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            group_reg <= group_next;
        end
    end

endmodule

FILE: rtl/core/indexed_sequence_table.sv
// Ordered table of up to CAPACITY signed words held in a row of cells, one word per
// cell; insert and remove shift the row by one place. Insert,
// remove, select, replace and unused kinds finish in the cycle the request
// transaction is taken and their result sits in the output register from the next cycle.
// Search compares every cell in that cycle, then a scanner walks the match flags
// eight cells per cycle and stops at the first group that holds a match or at the
// last group. A new request is taken whenever no search is running and the output
// register is empty or being read; the table starts empty after reset and needs no
// clearing pass.
module indexed_sequence_table
    import ist_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ist_req_if.sink   req,
    ist_rsp_if.source rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 ok_reg;
    logic                 ok_next;
    logic signed [31:0]   rd_reg;
    logic signed [31:0]   rd_next;
    logic [6:0]           found_reg;
    logic [6:0]           found_next;
    logic [6:0]           cnt_reg;
    logic [6:0]           cnt_next;

    cell_ctl_t            ctl;
    scan_res_t            scan;
    logic                 scan_start;
    logic [WORD_BITS-1:0] cell_data [CAPACITY+1];
    logic [CAPACITY-1:0]  cell_match;
    logic                 accept;
    logic [CMP_W-1:0]     pos_wide;
    logic [CMP_W-1:0]     count_wide;
    logic                 pos_valid;
    logic                 ins_ok;
    logic [CNT_W-1:0]     sel_idx;
    logic [WORD_BITS-1:0] sel_data;

    assign req.ready  = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;
    assign pos_wide   = CMP_W'(req.position);
    assign count_wide = CMP_W'(count_reg);
    assign pos_valid  = pos_wide < count_wide;
    assign ins_ok     = (count_reg < CNT_W'(CAPACITY)) && (pos_wide <= count_wide);
    assign sel_idx    = pos_valid ? CNT_W'(req.position) : (count_reg - CNT_W'(1));
    assign sel_data   = cell_data[sel_idx];

    // top end of the row feeds zeros on remove
    assign cell_data[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left;
        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_rest
            assign left = cell_data[i-1];
        end
        ist_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .idx        (CNT_W'(i)),
            .left_data  (left),
            .right_data (cell_data[i+1]),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    ist_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .match (cell_match),
        .res   (scan)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        rd_next        = rd_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        scan_start     = 1'b0;
        ctl.op         = CELL_HOLD;
        ctl.pos        = CNT_W'(req.position);
        ctl.count      = count_reg;
        ctl.word       = req.word[WORD_BITS-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            ok_next    = 1'b0;
            rd_next    = '0;
            found_next = '0;
            case (req.kind)
                KIND_INSERT:
                begin
                    if (ins_ok)
                    begin
                        ctl.op     = CELL_INSERT;
                        ok_next    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                KIND_REMOVE:
                begin
                    if (pos_valid)
                    begin
                        ctl.op     = CELL_REMOVE;
                        ok_next    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                KIND_SELECT:
                begin
                    ok_next = pos_valid;
                    if (count_reg != '0)
                    begin
                        rd_next = 32'(signed'(sel_data));
                    end
                end
                KIND_SEARCH:
                begin
                    ctl.op     = CELL_SEARCH;
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
                KIND_REPLACE:
                begin
                    if (pos_valid)
                    begin
                        ctl.op  = CELL_REPLACE;
                        ok_next = 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
            if (req.kind != KIND_SEARCH)
            begin
                out_valid_next = 1'b1;
                cnt_next       = 7'(count_next);
            end
        end

        if (state_reg == ST_SCAN && scan.done)
        begin
            state_next     = ST_IDLE;
            out_valid_next = 1'b1;
            ok_next        = scan.hit;
            rd_next        = '0;
            found_next     = scan.hit ? 7'(scan.index) : 7'(count_reg);
            cnt_next       = 7'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        rd_reg    <= rd_next;
        found_reg <= found_next;
        cnt_reg   <= cnt_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = ok_reg;
    assign rsp.read_word      = rd_reg;
    assign rsp.found_position = found_reg;
    assign rsp.entry_count    = cnt_reg;
    assign rsp.is_empty       = (cnt_reg == 7'd0);
    assign rsp.is_full        = (cnt_reg == 7'(CAPACITY));

endmodule
